// ===== sv/opke_pkg.sv =====
package opke_pkg;

	localparam int unsigned PAYLOAD_W = 64;
	localparam int unsigned POS_W = 4;            // longest run is 2 + 8 + 1 bytes
	localparam int unsigned SCALAR_BYTES = 8;
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;
	localparam logic [7:0] BYTE_NULL = 8'h00;
	localparam logic [7:0] BYTE_PRESENT = 8'h01;
	localparam logic [7:0] BYTE_MORE = 8'hFF;

	typedef enum logic [2:0] {
		KIND_NULL  = 3'd0,
		KIND_BOOL  = 3'd1,
		KIND_INT   = 3'd2,
		KIND_REAL  = 3'd3,
		KIND_TEXT  = 3'd4,
		KIND_BLOB  = 3'd5
	} kind_e;

	typedef struct packed {
		logic [2:0]  kind;
		logic [63:0] payload_bits;
		logic [3:0]  chunk_count;
		logic        final_chunk;
		logic        descending;
	} item_t;

	typedef struct packed {
		logic [7:0] key_byte;
		logic       run_last;
		logic       key_end;
	} result_t;

	// One classified request, ready for byte emission.
	typedef struct packed {
		logic [2:0]  kind;
		logic        hdr;         // emit 01 and the type code first
		logic        body_en;     // emit body bytes from data
		logic        body_chunk;  // body length is the chunk size, else a scalar word
		logic        tail_en;     // emit tail byte last
		logic [7:0]  tail_byte;
		logic        inv;
		logic        ends;
		logic [63:0] data;
	} job_t;

endpackage

// ===== sv/order_preserving_key_encoder.sv =====
// Order-preserving key encoder. Each request on the input queue port is one typed value
// (null, boolean, integer, real) or one chunk of a text or blob value; the block turns it
// into a run of key bytes whose unsigned byte order matches the value order, and hands
// them out one byte per pop. run_last marks the last byte of a request, key_end the last
// byte of a whole encoded value. A null gives 1 byte, a boolean 3, an integer or real 10,
// a first chunk 2 + CHUNK_BYTES + 1 (or 3 when empty), a continuation chunk
// CHUNK_BYTES + 1. Kinds 6 and 7 are taken and give nothing. Rate: the output register
// moves one byte per cycle while no full output waits for a pop; a request gives at most
// 11 bytes with the default chunk size; the front classifies a request in the cycle it is
// taken and a two-entry queue lets the next requests enter while the back still emits.
// Output is registered from the back's sequencer. No clearing after reset.
module order_preserving_key_encoder import opke_pkg::*; #(
	parameter int CHUNK_BYTES = 8
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	output logic    full,
	input  item_t   item,
	output logic    empty,
	input  logic    pop,
	output result_t result
);

	logic accept;
	logic job_valid;
	job_t job;
	logic q_wr;
	logic q_full;
	logic q_rd;
	logic q_empty;
	job_t q_job;

	// Hold the input while the queue has no room.
	assign full = q_full;
	assign accept = push && !q_full;
	assign q_wr = accept && job_valid;

	// Classify the request and track chunked values.
	opke_front #(.CHUNK_BYTES(CHUNK_BYTES)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.accept    (accept),
		.job_valid (job_valid),
		.job       (job)
	);

	// Decouple classification from byte emission.
	opke_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.wr_job (job),
		.full   (q_full),
		.rd     (q_rd),
		.rd_job (q_job),
		.empty  (q_empty)
	);

	// Advance through each request's bytes into the output register.
	opke_back #(.CHUNK_BYTES(CHUNK_BYTES)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_job   (q_job),
		.q_rd    (q_rd),
		.result  (result),
		.empty   (empty),
		.pop     (pop)
	);

	a_no_write_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_wr |-> !q_full)
		else $error("queue written while full");

	a_no_read_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_rd |-> !q_empty)
		else $error("queue read while empty");

	a_end_is_run_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.key_end) |-> result.run_last)
		else $error("key end without run end");

endmodule

// ===== sv/opke_front.sv =====
module opke_front import opke_pkg::*; #(
	parameter int CHUNK_BYTES = 8
) (
	input  logic  clk,
	input  logic  arst_n,
	input  item_t item,
	input  logic  accept,
	output logic  job_valid,
	output job_t  job
);

	logic inside_q;
	logic latched_desc_q;
	logic is_chunk;
	logic first;
	logic [3:0] count_cl;
	logic [63:0] chunk_data;
	logic chunk_ends;

	assign is_chunk = (item.kind == KIND_TEXT) || (item.kind == KIND_BLOB);
	assign first = !inside_q;
	assign count_cl = (item.chunk_count > 4'(CHUNK_BYTES)) ? 4'(CHUNK_BYTES) : item.chunk_count;
	assign chunk_ends = !((count_cl == 4'(CHUNK_BYTES)) && !item.final_chunk);

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			chunk_data[63 - 8*i -: 8] = (4'(i) < count_cl) ? item.payload_bits[63 - 8*i -: 8] : 8'h00;
		end
	end

	always_comb begin
		job_valid = (item.kind <= KIND_BLOB);
		job = '0;
		job.kind = item.kind;
		job.inv = item.descending;
		job.ends = 1'b1;
		unique case (item.kind)
			KIND_NULL: begin
				job.tail_en = 1'b1;
				job.tail_byte = BYTE_NULL;
			end
			KIND_BOOL: begin
				job.hdr = 1'b1;
				job.tail_en = 1'b1;
				job.tail_byte = {7'd0, |item.payload_bits};
			end
			KIND_INT: begin
				job.hdr = 1'b1;
				job.body_en = 1'b1;
				job.data = item.payload_bits ^ SIGN_BIT;
			end
			KIND_REAL: begin
				job.hdr = 1'b1;
				job.body_en = 1'b1;
				job.data = item.payload_bits[63] ? ~item.payload_bits : item.payload_bits ^ SIGN_BIT;
			end
			KIND_TEXT, KIND_BLOB: begin
				job.hdr = first;
				job.inv = first ? item.descending : latched_desc_q;
				job.body_en = !(first && (count_cl == 4'd0));
				job.body_chunk = 1'b1;
				job.data = chunk_data;
				job.tail_en = 1'b1;
				job.tail_byte = chunk_ends ? {4'd0, count_cl} : BYTE_MORE;
				job.ends = chunk_ends;
			end
			default: begin
				job_valid = 1'b0;
			end
		endcase
	end

	// Track an open text or blob value across chunks.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q <= 1'b0;
			latched_desc_q <= 1'b0;
		end else if (accept && job_valid) begin
			if (is_chunk) begin
				inside_q <= !chunk_ends;
				if (first) begin
					latched_desc_q <= item.descending;
				end
			end else begin
				inside_q <= 1'b0;
			end
		end
	end

endmodule

// ===== sv/opke_queue.sv =====
module opke_queue import opke_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  job_t wr_job,
	output logic full,
	input  logic rd,
	output job_t rd_job,
	output logic empty
);

	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	job_t slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign rd_job = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			slot_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CNT_W'(wr) - CNT_W'(rd);
		end
	end

endmodule

// ===== sv/opke_back.sv =====
module opke_back import opke_pkg::*; #(
	parameter int CHUNK_BYTES = 8
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    q_empty,
	input  job_t    q_job,
	output logic    q_rd,
	output result_t result,
	output logic    empty,
	input  logic    pop
);

	job_t job_q;
	logic [63:0] data_q;
	logic [POS_W-1:0] pos_q;
	logic busy_q;
	result_t out_q;
	logic out_v_q;

	logic [POS_W-1:0] hdr_n;
	logic [POS_W-1:0] body_n;
	logic [POS_W-1:0] total;
	logic in_hdr;
	logic in_body;
	logic last;
	logic fire;
	logic [7:0] raw_byte;

	assign hdr_n = job_q.hdr ? POS_W'(2) : '0;
	assign body_n = !job_q.body_en ? '0 :
		(job_q.body_chunk ? POS_W'(CHUNK_BYTES) : POS_W'(SCALAR_BYTES));
	assign total = hdr_n + body_n + POS_W'(job_q.tail_en);
	assign in_hdr = (pos_q < hdr_n);
	assign in_body = !in_hdr && (pos_q < hdr_n + body_n);
	assign last = (pos_q == total - 1'b1);
	assign fire = busy_q && (!out_v_q || pop);
	assign q_rd = (!busy_q || (fire && last)) && !q_empty;

	always_comb begin
		priority if (in_hdr) begin
			raw_byte = pos_q[0] ? {5'd0, job_q.kind} : BYTE_PRESENT;
		end else if (in_body) begin
			raw_byte = data_q[63:56];
		end else begin
			raw_byte = job_q.tail_byte;
		end
	end

	assign result = out_q;
	assign empty = !out_v_q;

	always_ff @(posedge clk) begin
		if (q_rd) begin
			job_q <= q_job;
			data_q <= q_job.data;
		end else if (fire && in_body) begin
			data_q <= {data_q[55:0], 8'h00};
		end
		if (fire) begin
			out_q.key_byte <= raw_byte ^ {8{job_q.inv}};
			out_q.run_last <= last;
			out_q.key_end <= last && job_q.ends;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (q_rd) begin
				busy_q <= 1'b1;
				pos_q <= '0;
			end else if (fire) begin
				busy_q <= !last;
				pos_q <= pos_q + 1'b1;
			end
			if (fire) begin
				out_v_q <= 1'b1;
			end else if (pop) begin
				out_v_q <= 1'b0;
			end
		end
	end

endmodule
